### rtl/core/rcss_pkg.sv
package rcss_pkg;

   localparam int unsigned MAX_REGIONS      = 32;
   localparam int unsigned MAX_REGION_BYTES = 1048576;

   localparam int unsigned BYTES_W  = 21;
   localparam int unsigned COUNT_W  = 6;
   localparam int unsigned LEN_W    = 26;
   localparam int unsigned TOTAL_W  = BYTES_W + COUNT_W;
   localparam int unsigned REGION_W = 5;
   localparam int unsigned OFFSET_W = 20;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [1:0] CSR_SRC_BYTES  = 2'd0;
   localparam logic [1:0] CSR_DEST_BYTES = 2'd1;
   localparam logic [1:0] CSR_SRC_COUNT  = 2'd2;
   localparam logic [1:0] CSR_DEST_COUNT = 2'd3;

   // register file contents, already clamped to the legal range
   typedef struct packed {
      logic [BYTES_W-1:0] src_bytes;
      logic [BYTES_W-1:0] dest_bytes;
      logic [COUNT_W-1:0] src_count;
      logic [COUNT_W-1:0] dest_count;
   } cfg_type;

   // one classified request between front and back
   typedef struct packed {
      logic             too_long;
      logic [LEN_W-1:0] len;
   } job_type;

   function automatic logic [BYTES_W-1:0] clamp_bytes(input logic [BYTES_W-1:0] v);
      logic [BYTES_W-1:0] r;
      if (v == '0) begin
         r = BYTES_W'(1);
      end else if (v > BYTES_W'(MAX_REGION_BYTES)) begin
         r = BYTES_W'(MAX_REGION_BYTES);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      if (v > COUNT_W'(MAX_REGIONS)) begin
         r = COUNT_W'(MAX_REGIONS);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### rtl/core/rcss_front.sv
module rcss_front import rcss_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [LEN_W-1:0] req_copy_length,
   output logic             push,
   output job_type          push_job,
   input  logic             queue_full
);

   logic             hold_valid_ff, hold_valid_in;
   logic [LEN_W-1:0] hold_len_ff, hold_len_in;
   logic [TOTAL_W-1:0] src_total, dest_total;
   logic             is_zero, leave, accept;

   assign src_total  = TOTAL_W'(cfg.src_bytes) * TOTAL_W'(cfg.src_count);
   assign dest_total = TOTAL_W'(cfg.dest_bytes) * TOTAL_W'(cfg.dest_count);

   assign is_zero = (hold_len_ff == '0);
   // drop zero-length requests here, never queue them
   assign leave   = hold_valid_ff && (is_zero || !queue_full);
   assign push    = hold_valid_ff && !is_zero && !queue_full;

   assign push_job.len      = hold_len_ff;
   assign push_job.too_long = (TOTAL_W'(hold_len_ff) > src_total) ||
                              (TOTAL_W'(hold_len_ff) > dest_total);

   assign req_stall = hold_valid_ff && !leave;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_len_in   = hold_len_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_len_in   = req_copy_length;
      end else if (leave) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_len_ff <= hold_len_in;
   end

endmodule

### rtl/core/rcss_queue.sv
module rcss_queue import rcss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    empty,
   output logic    full
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/core/rcss_back.sv
module rcss_back import rcss_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  job_type             head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [REGION_W-1:0] rsp_src_region,
   output logic [OFFSET_W-1:0] rsp_src_offset,
   output logic [REGION_W-1:0] rsp_dest_region,
   output logic [OFFSET_W-1:0] rsp_dest_offset,
   output logic [BYTES_W-1:0]  rsp_seg_length,
   output logic                rsp_too_long,
   output logic                rsp_last_segment
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W-1:0] s_ff, s_in, d_ff, d_in;
   logic [BYTES_W-1:0] so_ff, so_in, do_ff, do_in;

   logic                o_valid_ff, o_valid_in;
   logic [REGION_W-1:0] o_sr_ff, o_sr_in, o_dr_ff, o_dr_in;
   logic [OFFSET_W-1:0] o_so_ff, o_so_in, o_do_ff, o_do_in;
   logic [BYTES_W-1:0]  o_len_ff, o_len_in;
   logic                o_err_ff, o_err_in, o_last_ff, o_last_in;

   logic                load_ok;
   logic [BYTES_W-1:0]  src_left, dest_left, bound, seg, so_sum, do_sum;
   logic                is_last;

   assign load_ok   = !o_valid_ff || !rsp_stall;
   assign src_left  = cfg.src_bytes - so_ff;
   assign dest_left = cfg.dest_bytes - do_ff;
   assign bound     = (src_left < dest_left) ? src_left : dest_left;
   assign is_last   = (LEN_W'(bound) >= rem_ff);
   assign seg       = is_last ? rem_ff[BYTES_W-1:0] : bound;
   assign so_sum    = so_ff + seg;
   assign do_sum    = do_ff + seg;

   assign pop = (state_ff == ST_IDLE) && !empty && load_ok;

   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      s_in       = s_ff;
      d_in       = d_ff;
      so_in      = so_ff;
      do_in      = do_ff;
      o_valid_in = o_valid_ff && rsp_stall;
      o_sr_in    = o_sr_ff;
      o_dr_in    = o_dr_ff;
      o_so_in    = o_so_ff;
      o_do_in    = o_do_ff;
      o_len_in   = o_len_ff;
      o_err_in   = o_err_ff;
      o_last_in  = o_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (head.too_long) begin
                  o_valid_in = 1'b1;
                  o_sr_in    = '0;
                  o_dr_in    = '0;
                  o_so_in    = '0;
                  o_do_in    = '0;
                  o_len_in   = '0;
                  o_err_in   = 1'b1;
                  o_last_in  = 1'b1;
               end else begin
                  state_in = ST_RUN;
                  rem_in   = head.len;
                  s_in     = '0;
                  d_in     = '0;
                  so_in    = '0;
                  do_in    = '0;
               end
            end
         end
         ST_RUN: begin
            if (load_ok) begin
               o_valid_in = 1'b1;
               o_sr_in    = s_ff[REGION_W-1:0];
               o_dr_in    = d_ff[REGION_W-1:0];
               o_so_in    = so_ff[OFFSET_W-1:0];
               o_do_in    = do_ff[OFFSET_W-1:0];
               o_len_in   = seg;
               o_err_in   = 1'b0;
               o_last_in  = is_last;
               rem_in     = rem_ff - LEN_W'(seg);
               // advance to the next region on a boundary
               if (so_sum == cfg.src_bytes) begin
                  so_in = '0;
                  s_in  = s_ff + COUNT_W'(1);
               end else begin
                  so_in = so_sum;
               end
               if (do_sum == cfg.dest_bytes) begin
                  do_in = '0;
                  d_in  = d_ff + COUNT_W'(1);
               end else begin
                  do_in = do_sum;
               end
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         o_valid_ff <= o_valid_in;
      end
      rem_ff    <= rem_in;
      s_ff      <= s_in;
      d_ff      <= d_in;
      so_ff     <= so_in;
      do_ff     <= do_in;
      o_sr_ff   <= o_sr_in;
      o_dr_ff   <= o_dr_in;
      o_so_ff   <= o_so_in;
      o_do_ff   <= o_do_in;
      o_len_ff  <= o_len_in;
      o_err_ff  <= o_err_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_valid        = o_valid_ff;
   assign rsp_src_region   = o_sr_ff;
   assign rsp_dest_region  = o_dr_ff;
   assign rsp_src_offset   = o_so_ff;
   assign rsp_dest_offset  = o_do_ff;
   assign rsp_seg_length   = o_len_ff;
   assign rsp_too_long     = o_err_ff;
   assign rsp_last_segment = o_last_ff;

endmodule

### rtl/core/region_copy_segment_splitter.sv
// Flow: an accepted request is held in the front end, queued, then popped by the
//   back end, which registers its error result or its segments, one segment per
//   cycle while not stalled. A request has at most 63 segments, all registered before
//   the next is popped; a zero-length request is dropped in the front, no result.
// Reset: synchronous, active high; clears all valid state and loads the region
//   registers with 2048 bytes and one region per buffer.
module region_copy_segment_splitter import rcss_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // configuration write port
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [BYTES_W-1:0]  csr_wdata,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [LEN_W-1:0]    req_copy_length,
   // segment channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [REGION_W-1:0] rsp_src_region,
   output logic [OFFSET_W-1:0] rsp_src_offset,
   output logic [REGION_W-1:0] rsp_dest_region,
   output logic [OFFSET_W-1:0] rsp_dest_offset,
   output logic [BYTES_W-1:0]  rsp_seg_length,
   output logic                rsp_too_long,
   output logic                rsp_last_segment
);

   // Region registers. Clamp on write so front and back see legal sizes only:
   // a zero size reads as one byte, oversize values saturate. A zero count
   // stays zero, which makes any nonzero length an error.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SRC_BYTES:  cfg_in.src_bytes  = clamp_bytes(csr_wdata);
            CSR_DEST_BYTES: cfg_in.dest_bytes = clamp_bytes(csr_wdata);
            CSR_SRC_COUNT:  cfg_in.src_count  = clamp_count(csr_wdata[COUNT_W-1:0]);
            CSR_DEST_COUNT: cfg_in.dest_count = clamp_count(csr_wdata[COUNT_W-1:0]);
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_bytes  <= BYTES_W'(2048);
         cfg_ff.dest_bytes <= BYTES_W'(2048);
         cfg_ff.src_count  <= COUNT_W'(1);
         cfg_ff.dest_count <= COUNT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: hold one request, compare it against both buffer totals,
   // drop zero-length requests, push the rest into the job queue.
   logic    push, queue_full, queue_empty, pop;
   job_type push_job, head;

   rcss_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_copy_length (req_copy_length),
      .push            (push),
      .push_job        (push_job),
      .queue_full      (queue_full)
   );

   // Short job queue: lets the front take a new request while the back is
   // still walking the segments of an earlier one.
   rcss_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   // Back end: walk the byte range with running region/offset counters on
   // each side, cut each segment at the nearest boundary, and register every
   // result transaction; a stalled output backs up through the queue to the front.
   rcss_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head             (head),
      .empty            (queue_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_src_region   (rsp_src_region),
      .rsp_src_offset   (rsp_src_offset),
      .rsp_dest_region  (rsp_dest_region),
      .rsp_dest_offset  (rsp_dest_offset),
      .rsp_seg_length   (rsp_seg_length),
      .rsp_too_long     (rsp_too_long),
      .rsp_last_segment (rsp_last_segment)
   );

endmodule

### rtl/core/rcss_checker.sv
module rcss_checker import rcss_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [REGION_W-1:0] rsp_src_region,
   input logic [OFFSET_W-1:0] rsp_src_offset,
   input logic [REGION_W-1:0] rsp_dest_region,
   input logic [OFFSET_W-1:0] rsp_dest_offset,
   input logic [BYTES_W-1:0]  rsp_seg_length,
   input logic                rsp_too_long,
   input logic                rsp_last_segment
);

   // a stalled result transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_seg_length)
         && $stable(rsp_src_offset) && $stable(rsp_dest_offset)
         && $stable(rsp_last_segment))
      else $error("stalled result changed");

   // error result is the only one of its request and carries no segment
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_last_segment && rsp_seg_length == '0
         && rsp_src_region == '0 && rsp_dest_region == '0
         && rsp_src_offset == '0 && rsp_dest_offset == '0)
      else $error("malformed error result");

   // a real segment moves at least one byte
   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_too_long |-> rsp_seg_length != '0)
      else $error("empty segment");

   // reset drops any pending result
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind region_copy_segment_splitter rcss_checker u_rcss_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_src_region   (rsp_src_region),
   .rsp_src_offset   (rsp_src_offset),
   .rsp_dest_region  (rsp_dest_region),
   .rsp_dest_offset  (rsp_dest_offset),
   .rsp_seg_length   (rsp_seg_length),
   .rsp_too_long     (rsp_too_long),
   .rsp_last_segment (rsp_last_segment)
);

### dv/tb_region_copy_segment_splitter.sv
`timescale 1ns / 100ps

module tb_region_copy_segment_splitter;
   import rcss_pkg::*;

   // Run limits, set for the slowest legal run: 63 segments per copy and a
   // receiver stalling most of the time.
   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned SETTLE_CYCLES  = 8;      // front end may still chew on a zero copy
   localparam int unsigned DRAIN_LIMIT    = 50000;
   localparam int unsigned SEG_CAP        = 63;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned STAGES         = 3;
   localparam int unsigned PHASES         = 6;
   localparam int unsigned COPIES_PER_SET = 17;

   typedef struct packed {
      logic [REGION_W-1:0] src_region;
      logic [OFFSET_W-1:0] src_offset;
      logic [REGION_W-1:0] dest_region;
      logic [OFFSET_W-1:0] dest_offset;
      logic [BYTES_W-1:0]  seg_length;
      logic                too_long;
      logic                last_segment;
   } segment_type;

   localparam segment_type TOO_LONG_SEG = '{too_long: 1'b1, last_segment: 1'b1, default: '0};

   // Kinds of rows in the directed script.
   typedef enum logic [1:0] {
      ROW_SETTING,    // drain, then write all four region registers
      ROW_PREDICTED,  // copy checked against the splitter model below
      ROW_TYPED,      // copy with one hand-written expected transaction
      ROW_SILENT      // copy that must produce nothing
   } row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [BYTES_W-1:0] src_bytes;
      logic [BYTES_W-1:0] dest_bytes;
      logic [COUNT_W-1:0] src_count;
      logic [COUNT_W-1:0] dest_count;
      logic [LEN_W-1:0]   copy_len;
      segment_type        want;
   } script_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write;
   logic [1:0]          csr_index;
   logic [BYTES_W-1:0]  csr_wdata;
   logic                req_valid;
   logic                req_stall;
   logic [LEN_W-1:0]    req_copy_length;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [REGION_W-1:0] rsp_src_region;
   logic [OFFSET_W-1:0] rsp_src_offset;
   logic [REGION_W-1:0] rsp_dest_region;
   logic [OFFSET_W-1:0] rsp_dest_offset;
   logic [BYTES_W-1:0]  rsp_seg_length;
   logic                rsp_too_long;
   logic                rsp_last_segment;

   // Shadow copy of the region registers, raw as written (clamped on use).
   logic [BYTES_W-1:0]  src_bytes_q;
   logic [BYTES_W-1:0]  dest_bytes_q;
   logic [COUNT_W-1:0]  src_count_q;
   logic [COUNT_W-1:0]  dest_count_q;

   segment_type         owed_segments[$];
   script_row_type      script[$];
   int unsigned         mismatch_count = 0;
   int unsigned         cycle_count    = 0;
   int unsigned         tx_idle_pct    = 0;
   int unsigned         rx_idle_pct    = 0;
   int unsigned         rsp_hold_left  = 0;

   region_copy_segment_splitter uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_copy_length  (req_copy_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_src_region   (rsp_src_region),
      .rsp_src_offset   (rsp_src_offset),
      .rsp_dest_region  (rsp_dest_region),
      .rsp_dest_offset  (rsp_dest_offset),
      .rsp_seg_length   (rsp_seg_length),
      .rsp_too_long     (rsp_too_long),
      .rsp_last_segment (rsp_last_segment)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: kill the run if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Region size as the block uses it: zero means one byte, big sizes saturate.
   function automatic longint unsigned region_bytes(input logic [BYTES_W-1:0] raw);
      if (raw == '0) return 64'd1;
      if (raw > BYTES_W'(MAX_REGION_BYTES)) return 64'(MAX_REGION_BYTES);
      return 64'(raw);
   endfunction

   // Region count as the block uses it: saturate at the region limit, zero stays zero.
   function automatic longint unsigned region_count(input logic [COUNT_W-1:0] raw);
      if (raw > COUNT_W'(MAX_REGIONS)) return 64'(MAX_REGIONS);
      return 64'(raw);
   endfunction

   // Bytes that fit in both buffers under the current setting.
   function automatic longint unsigned usable_bytes();
      longint unsigned stot;
      longint unsigned dtot;
      stot = region_bytes(src_bytes_q) * region_count(src_count_q);
      dtot = region_bytes(dest_bytes_q) * region_count(dest_count_q);
      return (stot < dtot) ? stot : dtot;
   endfunction

   // Split one copy into segments and queue them as owed transactions.
   // Each segment stops at the nearer of the next source boundary, the next
   // destination boundary and the end of the copy.
   function automatic void split_copy(input logic [LEN_W-1:0] copy_len);
      longint unsigned len;
      longint unsigned sb;
      longint unsigned db;
      longint unsigned pos;
      longint unsigned s;
      longint unsigned d;
      longint unsigned stop;
      longint unsigned dstop;
      int unsigned     n;
      segment_type     seg;
      len = 64'(copy_len);
      sb  = region_bytes(src_bytes_q);
      db  = region_bytes(dest_bytes_q);
      if (len == 0) return;
      if (len > sb * region_count(src_count_q) || len > db * region_count(dest_count_q)) begin
         owed_segments = {owed_segments, TOO_LONG_SEG};
         return;
      end
      pos = 0;
      n   = 0;
      while (pos < len && n < SEG_CAP) begin
         s     = pos / sb;
         d     = pos / db;
         stop  = (s + 1) * sb;
         dstop = (d + 1) * db;
         if (dstop < stop) stop = dstop;
         if (len < stop) stop = len;
         seg.src_region   = REGION_W'(s);
         seg.src_offset   = OFFSET_W'(pos - s * sb);
         seg.dest_region  = REGION_W'(d);
         seg.dest_offset  = OFFSET_W'(pos - d * db);
         seg.seg_length   = BYTES_W'(stop - pos);
         seg.too_long     = 1'b0;
         seg.last_segment = (stop == len);
         owed_segments = {owed_segments, seg};
         n++;
         pos = stop;
      end
   endfunction

   function automatic void add_setting(input logic [BYTES_W-1:0] sb,
                                       input logic [BYTES_W-1:0] db,
                                       input logic [COUNT_W-1:0] sc,
                                       input logic [COUNT_W-1:0] dc);
      script_row_type row;
      row            = '{kind: ROW_SETTING, want: '0, copy_len: '0, default: '0};
      row.src_bytes  = sb;
      row.dest_bytes = db;
      row.src_count  = sc;
      row.dest_count = dc;
      script = {script, row};
   endfunction

   function automatic void add_copy(input row_kind_type kind, input logic [LEN_W-1:0] len,
                                    input segment_type want);
      script_row_type row;
      row          = '{kind: ROW_PREDICTED, want: '0, copy_len: '0, default: '0};
      row.kind     = kind;
      row.copy_len = len;
      row.want     = want;
      script = {script, row};
   endfunction

   // Compare one field of a transaction; keep going on a mismatch.
   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Scoreboard: sample accepted segments at the rising edge and retire the
   // oldest owed transaction.
   always @(posedge clock) begin
      segment_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_segments.size() == 0) begin
            $error("unexpected segment: src_region %0d seg_length %0d too_long %0d",
                   rsp_src_region, rsp_seg_length, rsp_too_long);
            mismatch_count++;
         end else begin
            want = owed_segments.pop_front();
            check_field("src_region",   64'(want.src_region),   64'(rsp_src_region));
            check_field("src_offset",   64'(want.src_offset),   64'(rsp_src_offset));
            check_field("dest_region",  64'(want.dest_region),  64'(rsp_dest_region));
            check_field("dest_offset",  64'(want.dest_offset),  64'(rsp_dest_offset));
            check_field("seg_length",   64'(want.seg_length),   64'(rsp_seg_length));
            check_field("too_long",     64'(want.too_long),     64'(rsp_too_long));
            check_field("last_segment", 64'(want.last_segment), 64'(rsp_last_segment));
         end
      end
   end

   // Receiver: stall at random, or hold off for a counted stretch when asked so
   // the block backs up into its input.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // Offer one copy transaction; idle first at random. Valid stays up after the
   // handshake for back-to-back copies. Predict on acceptance
   // unless the caller types its own expectation.
   task automatic offer_copy(input logic [LEN_W-1:0] len, input bit predict);
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_copy_length <= len;
      do @(posedge clock); while (req_stall);
      if (predict) split_copy(len);
   endtask

   // Drop valid and wait until every owed segment is back, then let the front
   // end settle.
   task automatic wait_all_segments();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [BYTES_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Reprogram all four region registers once the block is idle. Junk in the
   // upper write bits of the count registers must be ignored.
   task automatic apply_setting(input logic [BYTES_W-1:0] sb, input logic [BYTES_W-1:0] db,
                                input logic [COUNT_W-1:0] sc, input logic [COUNT_W-1:0] dc,
                                input bit junk_high);
      logic [BYTES_W-COUNT_W-1:0] junk_s;
      logic [BYTES_W-COUNT_W-1:0] junk_d;
      junk_s = junk_high ? (BYTES_W-COUNT_W)'($urandom) : '0;
      junk_d = junk_high ? (BYTES_W-COUNT_W)'($urandom) : '0;
      wait_all_segments();
      write_reg(CSR_SRC_BYTES,  sb);
      write_reg(CSR_DEST_BYTES, db);
      write_reg(CSR_SRC_COUNT,  {junk_s, sc});
      write_reg(CSR_DEST_COUNT, {junk_d, dc});
      @(negedge clock);
      csr_write    <= 1'b0;
      src_bytes_q  = sb;
      dest_bytes_q = db;
      src_count_q  = sc;
      dest_count_q = dc;
   endtask

   function automatic logic [BYTES_W-1:0] pick_region_bytes();
      case ($urandom_range(9))
         0:       return '0;
         1:       return BYTES_W'($urandom_range((1 << BYTES_W) - 1, MAX_REGION_BYTES));
         2, 3:    return BYTES_W'($urandom_range(16, 1));
         4, 5:    return BYTES_W'($urandom_range(4096, 1));
         default: return BYTES_W'($urandom_range(MAX_REGION_BYTES, 1));
      endcase
   endfunction

   function automatic logic [COUNT_W-1:0] pick_region_count();
      case ($urandom_range(9))
         0:       return '0;
         1:       return COUNT_W'($urandom_range((1 << COUNT_W) - 1, MAX_REGIONS + 1));
         2:       return COUNT_W'(MAX_REGIONS);
         default: return COUNT_W'($urandom_range(MAX_REGIONS, 1));
      endcase
   endfunction

   // Mostly copies that fit, with the odd zero, exact fit, overrun and raw value.
   function automatic logic [LEN_W-1:0] pick_length();
      longint unsigned room;
      room = usable_bytes();
      case ($urandom_range(19))
         0:       return '0;
         1:       return LEN_W'($urandom);
         2:       return LEN_W'(room + $urandom_range(64, 1));
         3:       return (room == 0) ? LEN_W'($urandom) : LEN_W'(room);
         default: return (room == 0) ? LEN_W'($urandom_range(64, 1))
                                     : LEN_W'($urandom_range(int'(room), 1));
      endcase
   endfunction

   // One random setting followed by a batch of copies. With hold set, stall the
   // receiver for a long stretch, and pause the sender halfway until all is back.
   task automatic random_phase(input bit hold);
      apply_setting(pick_region_bytes(), pick_region_bytes(),
                    pick_region_count(), pick_region_count(), $urandom_range(1));
      if (hold) rsp_hold_left = HOLD_CYCLES;
      for (int unsigned i = 0; i < COPIES_PER_SET; i++) begin
         if (hold && i == COPIES_PER_SET / 2) wait_all_segments();
         offer_copy(pick_length(), 1'b1);
      end
   endtask

   initial begin
      int unsigned drain_wait;
      reset           = 1'b1;
      csr_write       = 1'b0;
      csr_index       = CSR_SRC_BYTES;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_copy_length = '0;
      rsp_stall       = 1'b0;
      src_bytes_q     = BYTES_W'(2048);
      dest_bytes_q    = BYTES_W'(2048);
      src_count_q     = COUNT_W'(1);
      dest_count_q    = COUNT_W'(1);

      // Directed script. Reset setting first: 2048-byte regions, one per side.
      add_copy(ROW_SILENT,    '0, '0);
      add_copy(ROW_TYPED,     LEN_W'(1),
               '{seg_length: BYTES_W'(1), last_segment: 1'b1, default: '0});
      add_copy(ROW_TYPED,     LEN_W'(2048),
               '{seg_length: BYTES_W'(2048), last_segment: 1'b1, default: '0});
      add_copy(ROW_TYPED,     LEN_W'(2049), TOO_LONG_SEG);
      add_copy(ROW_TYPED,     '1, TOO_LONG_SEG);
      // Zero source size acts as one byte; oversize and overcount saturate.
      add_setting('0, '1, '1, COUNT_W'(MAX_REGIONS));
      add_copy(ROW_PREDICTED, LEN_W'(32), '0);
      add_copy(ROW_TYPED,     LEN_W'(33), TOO_LONG_SEG);
      // Largest buffers on both sides: copy the full span, then one byte more.
      add_setting(BYTES_W'(MAX_REGION_BYTES), BYTES_W'(MAX_REGION_BYTES),
                  COUNT_W'(MAX_REGIONS), COUNT_W'(MAX_REGIONS));
      add_copy(ROW_PREDICTED, LEN_W'(MAX_REGION_BYTES * MAX_REGIONS), '0);
      add_copy(ROW_TYPED,     LEN_W'(MAX_REGION_BYTES * MAX_REGIONS + 1), TOO_LONG_SEG);
      // Interleaved boundaries on the two sides.
      add_setting(BYTES_W'(3), BYTES_W'(5), COUNT_W'(MAX_REGIONS), COUNT_W'(MAX_REGIONS));
      add_copy(ROW_PREDICTED, LEN_W'(96), '0);
      add_copy(ROW_PREDICTED, LEN_W'(7), '0);
      // Empty destination: a zero copy stays silent, anything else overruns.
      add_setting(BYTES_W'(3), BYTES_W'(5), COUNT_W'(MAX_REGIONS), '0);
      add_copy(ROW_SILENT,    '0, '0);
      add_copy(ROW_TYPED,     LEN_W'(1), TOO_LONG_SEG);
      add_setting('1, BYTES_W'(MAX_REGION_BYTES - 1), COUNT_W'(1), COUNT_W'(MAX_REGIONS + 1));
      add_copy(ROW_PREDICTED, LEN_W'(MAX_REGION_BYTES), '0);
      add_copy(ROW_TYPED,     LEN_W'(MAX_REGION_BYTES + 1), TOO_LONG_SEG);
      // Off-by-one region sizes give the most segments a copy can produce.
      add_setting(BYTES_W'(MAX_REGION_BYTES - 1), BYTES_W'(MAX_REGION_BYTES),
                  COUNT_W'(MAX_REGIONS), COUNT_W'(MAX_REGIONS));
      add_copy(ROW_PREDICTED, LEN_W'((MAX_REGION_BYTES - 1) * MAX_REGIONS), '0);
      add_copy(ROW_TYPED,     LEN_W'(1 << (LEN_W - 1)), TOO_LONG_SEG);

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 30;
      rx_idle_pct = 30;
      foreach (script[i]) begin
         case (script[i].kind)
            ROW_SETTING: begin
               apply_setting(script[i].src_bytes, script[i].dest_bytes,
                             script[i].src_count, script[i].dest_count, 1'b0);
            end
            ROW_PREDICTED: begin
               offer_copy(script[i].copy_len, 1'b1);
            end
            ROW_TYPED: begin
               offer_copy(script[i].copy_len, 1'b0);
               owed_segments = {owed_segments, script[i].want};
            end
            default: begin
               offer_copy(script[i].copy_len, 1'b0);
            end
         endcase
      end

      // Random part: fast sender and busy receiver, then the reverse, then
      // full rate with one long receiver hold-off.
      for (int unsigned stage = 0; stage < STAGES; stage++) begin
         tx_idle_pct = (stage == 0) ? 15 : (stage == 1) ? 77 : 0;
         rx_idle_pct = (stage == 0) ? 77 : (stage == 1) ? 15 : 0;
         for (int unsigned ph = 0; ph < PHASES; ph++) begin
            random_phase(stage == STAGES - 1 && ph == 1);
         end
      end

      // Drain with a bound, then watch for stray segments.
      @(negedge clock);
      req_valid <= 1'b0;
      drain_wait = 0;
      while (owed_segments.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (owed_segments.size() != 0) begin
         $error("%0d expected segments never arrived", owed_segments.size());
         mismatch_count++;
      end

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/rcss_pkg.sv
rtl/core/rcss_front.sv
rtl/core/rcss_queue.sv
rtl/core/rcss_back.sv
rtl/core/region_copy_segment_splitter.sv
rtl/core/rcss_checker.sv
dv/tb_region_copy_segment_splitter.sv
